// ===== src/fbrd_pkg.sv =====
// Shared types, widths and codes for the formatted binary record deframer.
package fbrd_pkg;

   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;
   localparam int KIND_W = 2;
   localparam int ERR_W  = 3;

   localparam logic [WORD_W-1:0] MAX_LEN_RESET = 16'd512;
   localparam logic [WORD_W-1:0] HEADER_LEN    = 16'd4;
   localparam logic [BYTE_W-1:0] HDR_BYTE_1    = 8'h01;
   localparam logic [BYTE_W-1:0] HDR_BYTE_2    = 8'h00;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_REC_OK  = 2'd1,
      KIND_REC_ERR = 2'd2,
      KIND_END     = 2'd3
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_HEADER = 3'd1,
      ERR_NO_LENGTH  = 3'd2,
      ERR_LEN_RANGE  = 3'd3,
      ERR_SHORT_DATA = 3'd4,
      ERR_NO_CKSUM   = 3'd5,
      ERR_BAD_CKSUM  = 3'd6
   } err_type;

   // One result item as produced by the parser.
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] out_byte;
      logic [WORD_W-1:0] byte_offset;
      logic [WORD_W-1:0] payload_length;
      err_type           error_code;
   } result_type;

endpackage

// ===== src/fbrd_channels.sv =====
// Request and response channel interfaces for the record deframer.
interface fbrd_req_if
   import fbrd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface fbrd_rsp_if
   import fbrd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] out_kind;
   logic [BYTE_W-1:0] out_byte;
   logic [WORD_W-1:0] byte_offset;
   logic [WORD_W-1:0] payload_length;
   logic [ERR_W-1:0]  error_code;

   modport source (output valid, output out_kind, output out_byte, output byte_offset,
                   output payload_length, output error_code, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input byte_offset,
                   input payload_length, input error_code, output ready);
endinterface

// ===== src/formatted_binary_record_deframer_top.sv =====
// Top level of the formatted binary record deframer.
// A result appears on rsp in the cycle after the request that causes it is accepted.
// Throughput: one request per cycle unless a held result waits on rsp_chan.ready;
//   the phase update and the result decode are a single compare-and-add step, and
//   the response register frees in the same cycle that its item is taken.
// Reset (synchronous, active high): hunting for a record start, response empty,
//   max_record_length back to 512.
module formatted_binary_record_deframer_top
   import fbrd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   fbrd_req_if.sink          req_chan,
   fbrd_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data
);

   logic [WORD_W-1:0] max_len_ff;
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;

   logic       req_accept;
   result_type result;

   // Take a request whenever the response register is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   fbrd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .in_byte      (req_chan.in_byte),
      .end_of_input (req_chan.end_of_input),
      .max_len      (max_len_ff),
      .result       (result)
   );

   // Hold the configured maximum record length.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   // Response register: load on a request that yields a result, clear once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset; advance it only with a new result.
   always_ff @(posedge clock) begin
      if (req_accept && result.valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_kind       = rsp_data_ff.kind;
   assign rsp_chan.out_byte       = rsp_data_ff.out_byte;
   assign rsp_chan.byte_offset    = rsp_data_ff.byte_offset;
   assign rsp_chan.payload_length = rsp_data_ff.payload_length;
   assign rsp_chan.error_code     = rsp_data_ff.error_code;

endmodule

// ===== src/fbrd_parser.sv =====
// Record parser: phase machine, length and checksum tracking, result decode.
module fbrd_parser
   import fbrd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              end_of_input,
   input  logic [WORD_W-1:0] max_len,
   output result_type        result
);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_HDR2  = 3'd1,
      PH_LENLO = 3'd2,
      PH_LENHI = 3'd3,
      PH_DATA  = 3'd4,
      PH_CKSUM = 3'd5,
      PH_ERROR = 3'd6
   } phase_type;

   phase_type         phase_ff,   phase_in;
   logic [BYTE_W-1:0] len_low_ff, len_low_in;
   logic [WORD_W-1:0] remain_ff,  remain_in;
   logic [WORD_W-1:0] count_ff,   count_in;
   logic [BYTE_W-1:0] sum_ff,     sum_in;

   logic [WORD_W-1:0] len_word;
   logic [BYTE_W-1:0] sum_next;

   assign len_word = {in_byte, len_low_ff};
   assign sum_next = sum_ff + in_byte;

   always_comb begin
      phase_in   = phase_ff;
      len_low_in = len_low_ff;
      remain_in  = remain_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      result     = '0;
      result.kind       = KIND_PAYLOAD;
      result.error_code = ERR_NONE;

      if (end_of_input) begin
         // every stream end returns to hunting
         phase_in = PH_HUNT;
         unique case (phase_ff)
            PH_HUNT: begin
               result.valid = 1'b1;
               result.kind  = KIND_END;
            end
            PH_HDR2: begin
               result.valid      = 1'b1;
               result.kind       = KIND_REC_ERR;
               result.error_code = ERR_BAD_HEADER;
            end
            PH_LENLO, PH_LENHI: begin
               result.valid      = 1'b1;
               result.kind       = KIND_REC_ERR;
               result.error_code = ERR_NO_LENGTH;
            end
            PH_DATA: begin
               result.valid      = 1'b1;
               result.kind       = KIND_REC_ERR;
               result.error_code = ERR_SHORT_DATA;
            end
            PH_CKSUM: begin
               result.valid      = 1'b1;
               result.kind       = KIND_REC_ERR;
               result.error_code = ERR_NO_CKSUM;
            end
            default: begin
            end
         endcase
      end else begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (in_byte == HDR_BYTE_1) begin
                  sum_in   = HDR_BYTE_1;
                  phase_in = PH_HDR2;
               end else if (in_byte != '0) begin
                  phase_in          = PH_ERROR;
                  result.valid      = 1'b1;
                  result.kind       = KIND_REC_ERR;
                  result.error_code = ERR_BAD_HEADER;
               end
            end
            PH_HDR2: begin
               if (in_byte == HDR_BYTE_2) begin
                  phase_in = PH_LENLO;
               end else begin
                  phase_in          = PH_ERROR;
                  result.valid      = 1'b1;
                  result.kind       = KIND_REC_ERR;
                  result.error_code = ERR_BAD_HEADER;
               end
            end
            PH_LENLO: begin
               len_low_in = in_byte;
               sum_in     = sum_next;
               phase_in   = PH_LENHI;
            end
            PH_LENHI: begin
               if (len_word < HEADER_LEN || len_word > max_len) begin
                  phase_in          = PH_ERROR;
                  result.valid      = 1'b1;
                  result.kind       = KIND_REC_ERR;
                  result.error_code = ERR_LEN_RANGE;
               end else begin
                  sum_in    = sum_next;
                  remain_in = len_word - HEADER_LEN;
                  count_in  = '0;
                  phase_in  = (len_word == HEADER_LEN) ? PH_CKSUM : PH_DATA;
               end
            end
            PH_DATA: begin
               sum_in             = sum_next;
               result.valid       = 1'b1;
               result.kind        = KIND_PAYLOAD;
               result.out_byte    = in_byte;
               result.byte_offset = count_ff;
               count_in           = count_ff + WORD_W'(1);
               remain_in          = remain_ff - WORD_W'(1);
               if (remain_ff == WORD_W'(1)) begin
                  phase_in = PH_CKSUM;
               end
            end
            PH_CKSUM: begin
               sum_in       = sum_next;
               result.valid = 1'b1;
               if (sum_next != '0) begin
                  phase_in          = PH_ERROR;
                  result.kind       = KIND_REC_ERR;
                  result.error_code = ERR_BAD_CKSUM;
               end else begin
                  phase_in              = PH_HUNT;
                  result.kind           = KIND_REC_OK;
                  result.payload_length = count_ff;
               end
            end
            default: begin
               // drop bytes until the stream ends
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         len_low_ff <= '0;
         remain_ff  <= '0;
         count_ff   <= '0;
         sum_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         len_low_ff <= len_low_in;
         remain_ff  <= remain_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
      end
   end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the formatted binary record deframer.
`timescale 1ns / 100ps

module tb
   import fbrd_pkg::*;
();

   // Give up after this many cycles in which no request, result or register write moves.
   localparam int QUIET_LIMIT = 2000;
   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h00;

   // Parser position, kept by the predictor in step with the block.
   typedef enum logic [2:0] {
      SEEK_HDR1,
      SEEK_HDR2,
      READ_LEN_LO,
      READ_LEN_HI,
      READ_PAYLOAD,
      READ_CKSUM,
      DISCARD
   } parse_phase_type;

   // One request: a stream byte, or the end-of-stream marker.
   typedef struct packed {
      logic [BYTE_W-1:0] b;
      logic              eoi;
   } stream_unit_type;

   // A result typed in by hand, which then stands in place of the predicted one.
   typedef struct packed {
      logic       pinned;
      result_type res;
   } pin_tag_type;

   typedef struct packed {
      stream_unit_type unit;
      pin_tag_type     tag;
   } directed_row_type;

   localparam pin_tag_type PREDICTED    = '0;
   localparam pin_tag_type TYPED_SILENT = '{pinned: 1'b1, res: '0};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [WORD_W-1:0] csr_wr_data;

   fbrd_req_if req ();
   fbrd_rsp_if rsp ();

   formatted_binary_record_deframer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Predictor state and its copy of the length limit, both at their reset values.
   parse_phase_type   pred_phase   = SEEK_HDR1;
   logic [BYTE_W-1:0] pred_len_lo  = '0;
   logic [WORD_W-1:0] pred_left    = '0;
   logic [WORD_W-1:0] pred_count   = '0;
   logic [BYTE_W-1:0] pred_sum     = '0;
   logic [WORD_W-1:0] pred_max_len = MAX_LEN_RESET;

   result_type       awaited_outputs[$];
   pin_tag_type      typed_outcomes[$];
   directed_row_type directed_rows[$];
   int               mismatches    = 0;
   int               requests_sent = 0;
   int               burst_left    = 0;
   int               quiet_cycles  = 0;
   int               ready_age     = 0;
   logic [15:0]      ready_pattern = '1;

   function automatic pin_tag_type typed(kind_type k, logic [WORD_W-1:0] plen, err_type e);
      pin_tag_type t;
      t = '0;
      t.pinned             = 1'b1;
      t.res.valid          = 1'b1;
      t.res.kind           = k;
      t.res.payload_length = plen;
      t.res.error_code     = e;
      return t;
   endfunction

   // Abandon the record: back to hunting if the stream has ended, otherwise
   // drop everything up to the end marker.
   function automatic result_type record_fault(err_type code, logic ended);
      result_type r;
      r            = '0;
      r.valid      = 1'b1;
      r.kind       = KIND_REC_ERR;
      r.error_code = code;
      pred_phase   = ended ? SEEK_HDR1 : DISCARD;
      return r;
   endfunction

   // Advance the predictor by one request and return the result it causes, if any.
   function automatic result_type deframe_byte(logic [BYTE_W-1:0] b, logic eoi);
      result_type        r;
      logic [WORD_W-1:0] len;
      r = '0;
      if (eoi) begin
         case (pred_phase)
            SEEK_HDR1: begin
               r.valid = 1'b1;
               r.kind  = KIND_END;
            end
            SEEK_HDR2:                r = record_fault(ERR_BAD_HEADER, 1'b1);
            READ_LEN_LO, READ_LEN_HI: r = record_fault(ERR_NO_LENGTH, 1'b1);
            READ_PAYLOAD:             r = record_fault(ERR_SHORT_DATA, 1'b1);
            READ_CKSUM:               r = record_fault(ERR_NO_CKSUM, 1'b1);
            default:                  pred_phase = SEEK_HDR1;
         endcase
      end else begin
         case (pred_phase)
            SEEK_HDR1: begin
               if (b == HDR_BYTE_1) begin
                  pred_sum   = HDR_BYTE_1;
                  pred_phase = SEEK_HDR2;
               end else if (b != FILL_BYTE) begin
                  r = record_fault(ERR_BAD_HEADER, 1'b0);
               end
            end
            SEEK_HDR2: begin
               if (b != HDR_BYTE_2) r = record_fault(ERR_BAD_HEADER, 1'b0);
               else pred_phase = READ_LEN_LO;
            end
            READ_LEN_LO: begin
               pred_len_lo = b;
               pred_sum    = pred_sum + b;
               pred_phase  = READ_LEN_HI;
            end
            READ_LEN_HI: begin
               len = {b, pred_len_lo};
               if (len < HEADER_LEN || len > pred_max_len) begin
                  r = record_fault(ERR_LEN_RANGE, 1'b0);
               end else begin
                  pred_sum   = pred_sum + b;
                  pred_left  = len - HEADER_LEN;
                  pred_count = '0;
                  pred_phase = (pred_left == '0) ? READ_CKSUM : READ_PAYLOAD;
               end
            end
            READ_PAYLOAD: begin
               pred_sum      = pred_sum + b;
               r.valid       = 1'b1;
               r.kind        = KIND_PAYLOAD;
               r.out_byte    = b;
               r.byte_offset = pred_count;
               pred_count    = pred_count + 16'd1;
               pred_left     = pred_left - 16'd1;
               if (pred_left == '0) pred_phase = READ_CKSUM;
            end
            READ_CKSUM: begin
               pred_sum = pred_sum + b;
               if (pred_sum != '0) begin
                  r = record_fault(ERR_BAD_CKSUM, 1'b0);
               end else begin
                  pred_phase       = SEEK_HDR1;
                  r.valid          = 1'b1;
                  r.kind           = KIND_REC_OK;
                  r.payload_length = pred_count;
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   // Present one request, pacing the sender in bursts with random gaps between them,
   // and hold it until the block takes it. Always entered just after a rising edge.
   task automatic send_paced(stream_unit_type u, pin_tag_type tag);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) gap = 0;
         else if ($urandom_range(0, 9) == 0) gap = $urandom_range(15, 40);
         else gap = $urandom_range(1, 5);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      typed_outcomes.push_back(tag);
      req.valid        <= 1'b1;
      req.in_byte      <= u.b;
      req.end_of_input <= u.eoi;
      requests_sent++;
      do @(posedge clock); while (!req.ready);
   endtask

   // One record: optional fill, header, length, payload and checksum, sometimes
   // spoilt on purpose. A record that ends in an error is followed by an end
   // marker, so that the block does not sit discarding the next records.
   task automatic send_record();
      stream_unit_type   seq[$];
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      logic [WORD_W-1:0] len_word;
      int                lead, plen, pick, flaw, cut;
      logic              spoilt;
      lead = $urandom_range(0, 2);
      repeat (lead) seq.push_back('{FILL_BYTE, 1'b0});
      pick = $urandom_range(0, 9);
      flaw = $urandom_range(0, 11);
      if (pick == 0) plen = 0;
      else if (pick == 1 && pred_max_len >= HEADER_LEN && pred_max_len <= 16'd44)
         plen = int'(pred_max_len - HEADER_LEN);
      else plen = $urandom_range(1, 16);
      len_word = 16'(plen + 4);
      if (flaw == 3) len_word = 16'($urandom_range(0, 3));
      else if (flaw == 4 && pred_max_len != 16'hFFFF) len_word = pred_max_len + 16'd1;
      spoilt = (len_word < HEADER_LEN || len_word > pred_max_len);
      // The rest of a rejected record is dropped unread: keep it short.
      if (spoilt) plen = $urandom_range(0, 3);
      seq.push_back('{HDR_BYTE_1, 1'b0});
      seq.push_back('{HDR_BYTE_2, 1'b0});
      seq.push_back('{len_word[7:0], 1'b0});
      seq.push_back('{len_word[15:8], 1'b0});
      sum = HDR_BYTE_1 + HDR_BYTE_2 + len_word[7:0] + len_word[15:8];
      if (flaw == 0) begin
         if ($urandom_range(0, 1) == 0) seq[lead].b = 8'($urandom_range(2, 255));
         else seq[lead + 1].b = 8'($urandom_range(1, 255));
      end
      repeat (plen) begin
         b   = 8'($urandom);
         sum = sum + b;
         seq.push_back('{b, 1'b0});
      end
      if (flaw == 1) seq.push_back('{8'(8'h00 - sum) + 8'($urandom_range(1, 255)), 1'b0});
      else seq.push_back('{8'(8'h00 - sum), 1'b0});
      if (flaw == 2) begin
         // Cut the record short anywhere after its first header byte.
         cut = $urandom_range(lead + 1, seq.size() - 1);
         while (seq.size() > cut) void'(seq.pop_back());
         seq.push_back('{8'($urandom), 1'b1});
      end else if (flaw <= 1 || spoilt || $urandom_range(0, 4) == 0) begin
         seq.push_back('{8'($urandom), 1'b1});
      end
      foreach (seq[i]) send_paced(seq[i], PREDICTED);
   endtask

   // A few raw bytes followed by an end marker.
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) send_paced('{8'($urandom), 1'b0}, PREDICTED);
      send_paced('{8'($urandom), 1'b1}, PREDICTED);
   endtask

   // Drop valid and wait until every awaited result is in, then let requests that
   // cause no result pass through the block's response register.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_max_len(logic [WORD_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      pred_max_len  = v;
   endtask

   // Receiver: stall on a rotating 16-bit pattern, redrawn when ready_age runs out. One
   // pattern in three is all ones; the others always carry at least one ready bit.
   always @(posedge clock) begin
      if (ready_age == 0) begin
         ready_age     = 48;
         ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'd1);
      end
      ready_age--;
      rsp.ready    <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
   end

   // Predict on every accepted request, check every accepted result.
   always @(posedge clock) begin
      result_type  predicted;
      result_type  want;
      pin_tag_type tag;
      logic        bad;
      if (!reset) begin
         if (req.valid && req.ready) begin
            tag       = typed_outcomes.pop_front();
            predicted = deframe_byte(req.in_byte, req.end_of_input);
            if (tag.pinned) predicted = tag.res;
            if (predicted.valid) awaited_outputs.push_back(predicted);
         end
         if (rsp.valid && rsp.ready) begin
            if (awaited_outputs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: kind=%0d byte=%h off=%0d len=%0d err=%0d",
                           rsp.out_kind, rsp.out_byte, rsp.byte_offset,
                           rsp.payload_length, rsp.error_code);
            end else begin
               want = awaited_outputs.pop_front();
               bad  = (rsp.out_kind != want.kind) || (rsp.out_byte != want.out_byte) ||
                      (rsp.byte_offset != want.byte_offset) ||
                      (rsp.payload_length != want.payload_length) ||
                      (rsp.error_code != want.error_code);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected kind=%0d byte=%h off=%0d len=%0d err=%0d,",
                               " got kind=%0d byte=%h off=%0d len=%0d err=%0d"},
                              want.kind, want.out_byte, want.byte_offset,
                              want.payload_length, want.error_code,
                              rsp.out_kind, rsp.out_byte, rsp.byte_offset,
                              rsp.payload_length, rsp.error_code);
               end
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [WORD_W-1:0] settings[7];
      int                quota;
      int                start;
      req.valid        = 1'b0;
      req.in_byte      = '0;
      req.end_of_input = 1'b0;
      rsp.ready        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;

      // Directed part, run at the reset length limit of 512.
      directed_rows = '{
         // end marker while hunting, then a fill byte that is skipped
         '{'{8'hFF, 1'b1}, typed(KIND_END, 16'd0, ERR_NONE)},
         '{'{8'h00, 1'b0}, TYPED_SILENT},
         // length word of exactly 4: no payload, checksum follows at once
         '{'{8'h01, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b0}, PREDICTED},
         '{'{8'h04, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b0}, PREDICTED},
         '{'{8'hFB, 1'b0}, typed(KIND_REC_OK, 16'd0, ERR_NONE)},
         // bad first header byte; the next byte is dropped, the end marker is silent
         '{'{8'hFE, 1'b0}, typed(KIND_REC_ERR, 16'd0, ERR_BAD_HEADER)},
         '{'{8'hFF, 1'b0}, TYPED_SILENT},
         '{'{8'h00, 1'b1}, TYPED_SILENT},
         // stream ends in place of the second header byte
         '{'{8'h01, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b1}, typed(KIND_REC_ERR, 16'd0, ERR_BAD_HEADER)},
         // one payload byte of all ones, then a checksum that leaves a residue
         '{'{8'h01, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b0}, PREDICTED},
         '{'{8'h05, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b0}, PREDICTED},
         '{'{8'hFF, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b0}, typed(KIND_REC_ERR, 16'd0, ERR_BAD_CKSUM)},
         '{'{8'h00, 1'b1}, TYPED_SILENT},
         // length equal to the limit is accepted; stream ends before any payload
         '{'{8'h01, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b0}, PREDICTED},
         '{'{8'h02, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b1}, typed(KIND_REC_ERR, 16'd0, ERR_SHORT_DATA)},
         // largest length word is out of range
         '{'{8'h01, 1'b0}, PREDICTED},
         '{'{8'h00, 1'b0}, PREDICTED},
         '{'{8'hFF, 1'b0}, PREDICTED},
         '{'{8'hFF, 1'b0}, typed(KIND_REC_ERR, 16'd0, ERR_LEN_RANGE)},
         '{'{8'h00, 1'b1}, TYPED_SILENT}
      };

      // Hold reset, then release it on an edge.
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_paced(directed_rows[i].unit, directed_rows[i].tag);

      // Random part: one phase per limit setting, extremes and below-minimum values
      // included; at limits under 4 every record is rejected, so keep those short.
      settings = '{16'd20, HEADER_LEN, 16'd3, 16'hFFFF, 16'd0,
                   16'($urandom_range(5, 60)), MAX_LEN_RESET};
      foreach (settings[k]) begin
         drain();
         set_max_len(settings[k]);
         quota = (settings[k] < HEADER_LEN) ? 40 : 110;
         start = requests_sent;
         while (requests_sent - start < quota) begin
            if ($urandom_range(0, 11) == 0) send_noise();
            else send_record();
         end
      end

      drain();
      repeat (6) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
